/* design/sinusoidal_gait_joint_generator_macros.svh */
// Assertion macros shared by the gait generator modules.
`ifndef SINUSOIDAL_GAIT_JOINT_GENERATOR_MACROS_SVH
`define SINUSOIDAL_GAIT_JOINT_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SGJG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SGJG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/sgjg_pkg.sv */
// Shared types, constants and the sine table builder of the gait generator.
`default_nettype none

package sgjg_pkg;

   // Limb order of the result beats
   typedef enum logic [1:0] {
      LIMB_LL,
      LIMB_RL,
      LIMB_LA,
      LIMB_RA
   } limb_type;

   // Control token that travels down the pipeline beside the data
   typedef struct packed {
      logic     valid;
      limb_type limb;
   } tok_type;

   // Target height 0.92 m in Q3.12
   localparam logic signed [14:0] H_TARGET = 15'sd3768;
   // Velocity: error + 5 rounds half up, offset keeps the numerator positive
   localparam logic [15:0] VEL_NUM_OFFSET = 16'd12625;
   // Reciprocal of ten, exact for numerators below 2^18
   localparam logic [30:0] VEL_RECIP      = 31'd52429;
   localparam int          VEL_RECIP_SHIFT = 19;
   // 0.45 m/s (1843) minus the offset quotient (1262)
   localparam logic [15:0] VEL_BASE       = 16'd581;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // First-quarter sine sample u, odd Taylor series to x^11 in Q30
   function automatic logic [63:0] sine_quarter(input int unsigned u,
                                                input int unsigned tbits,
                                                input int unsigned fbits);
      logic [63:0] q;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] r;
      logic [63:0] s;
      q  = 64'(u) << (32 - tbits);
      a  = (q * HALF_PI_Q30) >> 30;
      a2 = (a * a) >> 30;
      r  = Q30_ONE;
      r  = Q30_ONE - ((a2 * r) >> 30) / 64'd110;
      r  = Q30_ONE - ((a2 * r) >> 30) / 64'd72;
      r  = Q30_ONE - ((a2 * r) >> 30) / 64'd42;
      r  = Q30_ONE - ((a2 * r) >> 30) / 64'd20;
      r  = Q30_ONE - ((a2 * r) >> 30) / 64'd6;
      s  = (a * r) >> 30;
      return (s + (64'd1 << (29 - fbits))) >> (30 - fbits);
   endfunction

   function automatic logic limb_is_leg(input limb_type l);
      return (l == LIMB_LL) || (l == LIMB_RL);
   endfunction

   // Right leg and left arm run half a cycle out of phase
   function automatic logic limb_opposite(input limb_type l);
      return (l == LIMB_RL) || (l == LIMB_LA);
   endfunction

endpackage

`default_nettype wire

/* design/sgjg_feed.sv */
// Input hold register, limb sequencer and phase/quadrant decode stage.
`default_nettype none
`include "sinusoidal_gait_joint_generator_macros.svh"

module sgjg_feed
   import sgjg_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [31:0]                  sim_time,
   input  wire logic [13:0]                  com_height,
   input  wire logic                         com_known,
   output tok_type                           tok,
   output logic [SINE_TABLE_BITS-2:0]        u_s,
   output logic                              neg_s,
   output logic [SINE_TABLE_BITS-2:0]        u_c,
   output logic                              neg_c,
   output logic signed [14:0]                err,
   output logic [14:0]                       vel_num
);

   localparam int B = SINE_TABLE_BITS;
   localparam logic [B-1:0] HALF_IDX = {1'b1, {(B-1){1'b0}}};
   localparam logic [B-1:0] QTR_IDX  = {2'b01, {(B-2){1'b0}}};
   localparam logic [B-2:0] QTR_U    = {1'b1, {(B-2){1'b0}}};

   logic        hold_v_ff, hold_v_in;
   limb_type    limb_ff, limb_in;
   logic [31:0] time_ff;
   logic [13:0] height_ff;
   logic        known_ff;
   logic        take;
   logic        issue;

   tok_type             tok_ff, tok_in;
   logic [B-2:0]        u_s_ff, u_s_in, u_c_ff, u_c_in;
   logic                neg_s_ff, neg_s_in, neg_c_ff, neg_c_in;
   logic signed [14:0]  err_ff, err_in;
   logic [14:0]         vnum_ff, vnum_in;

   logic [17:0]  phase;
   logic [B-1:0] base;
   logic [B-1:0] idx_s;
   logic [B-1:0] idx_c;

   // Take a new item once the held one has issued its last limb
   assign req_tready = !hold_v_ff || (adv && (limb_ff == LIMB_RA));
   assign take       = req_tvalid && req_tready;
   assign issue      = hold_v_ff && adv;

   // Advance the limb sequencer
   always_comb begin
      hold_v_in = hold_v_ff;
      limb_in   = limb_ff;
      if (issue) begin
         if (limb_ff == LIMB_RA) begin
            hold_v_in = 1'b0;
         end else begin
            limb_in = limb_type'(2'(limb_ff + 2'd1));
         end
      end
      if (take) begin
         hold_v_in = 1'b1;
         limb_in   = LIMB_LL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         limb_ff   <= LIMB_LL;
      end else begin
         hold_v_ff <= hold_v_in;
         limb_ff   <= limb_in;
      end
   end

   // Hold the item payload
   always_ff @(posedge clock) begin
      if (take) begin
         time_ff   <= sim_time;
         height_ff <= com_height;
         known_ff  <= com_known;
      end
   end

   // Phase is 5 * time mod 2^18; decode quadrant and mirrored quarter index
   always_comb begin
      phase  = time_ff[17:0] + {time_ff[15:0], 2'b00};
      base   = phase[17 -: B];
      idx_s  = base + (limb_opposite(limb_ff) ? HALF_IDX : '0);
      idx_c  = idx_s + QTR_IDX;
      u_s_in = idx_s[B-2] ? QTR_U - {1'b0, idx_s[B-3:0]} : {1'b0, idx_s[B-3:0]};
      u_c_in = idx_c[B-2] ? QTR_U - {1'b0, idx_c[B-3:0]} : {1'b0, idx_c[B-3:0]};
      neg_s_in = idx_s[B-1];
      neg_c_in = idx_c[B-1];
      tok_in.valid = hold_v_ff;
      tok_in.limb  = limb_ff;
   end

   // Height error and the positive velocity numerator
   always_comb begin
      err_in  = known_ff ? (H_TARGET - signed'({1'b0, height_ff})) : '0;
      vnum_in = 15'(16'(err_in) + VEL_NUM_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_s_ff   <= u_s_in;
         u_c_ff   <= u_c_in;
         neg_s_ff <= neg_s_in;
         neg_c_ff <= neg_c_in;
         err_ff   <= err_in;
         vnum_ff  <= vnum_in;
      end
   end

   assign tok     = tok_ff;
   assign u_s     = u_s_ff;
   assign u_c     = u_c_ff;
   assign neg_s   = neg_s_ff;
   assign neg_c   = neg_c_ff;
   assign err     = err_ff;
   assign vel_num = vnum_ff;

   `SGJG_ASSERT_NEXT(a_limb_continues, clock, reset, hold_v_ff && adv && (limb_ff != LIMB_RA), hold_v_ff && (limb_ff != LIMB_LL), "held item dropped before its last limb")
   `SGJG_ASSERT_NEXT(a_token_issued, clock, reset, hold_v_ff && adv, tok_ff.valid && (tok_ff.limb == $past(limb_ff)), "issued limb token lost or mislabeled")

endmodule

`default_nettype wire

/* design/sgjg_sine.sv */
// Quarter-wave sine table lookup, height bias and velocity stage.
`default_nettype none

module sgjg_sine
   import sgjg_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int ANGLE_FRAC_BITS = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire tok_type                         tok_i,
   input  wire logic [SINE_TABLE_BITS-2:0]      u_s,
   input  wire logic                            neg_s,
   input  wire logic [SINE_TABLE_BITS-2:0]      u_c,
   input  wire logic                            neg_c,
   input  wire logic signed [14:0]              err,
   input  wire logic [14:0]                     vel_num,
   output tok_type                              tok_o,
   output logic signed [ANGLE_FRAC_BITS+2:0]    sin_s,
   output logic signed [ANGLE_FRAC_BITS+2:0]    sin_c,
   output logic signed [ANGLE_FRAC_BITS+7:0]    bias,
   output logic signed [15:0]                   vel
);

   localparam int F       = ANGLE_FRAC_BITS;
   localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
   localparam int SW      = F + 2;
   localparam int W       = F + 8;
   localparam int VW      = F + 12;
   localparam int BUP     = (F >= 12) ? F - 12 : 0;
   localparam int BDN     = (F < 12) ? 12 - F : 0;
   localparam logic signed [VW-1:0] BRND = VW'((longint'(1) << BDN) >> 1);

   logic [SW-1:0] rom [QUARTER+1];

   // Constant quarter-wave table, endpoint included for the mirrored peak
   for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
      assign rom[gi] = SW'(sine_quarter(gi, SINE_TABLE_BITS, F));
   end

   tok_type              tok_ff;
   logic signed [F+2:0]  s_ff, s_in, c_ff, c_in;
   logic signed [W-1:0]  bias_ff, bias_in;
   logic signed [15:0]   vel_ff, vel_in;
   logic signed [17:0]   err18;
   logic signed [17:0]   err5;
   logic signed [VW-1:0] err_ext;
   logic [30:0]          vprod;
   logic [11:0]          vquo;

   // Look up both sines and apply the half-wave sign
   always_comb begin
      s_in = signed'({1'b0, rom[u_s]});
      c_in = signed'({1'b0, rom[u_c]});
      if (neg_s) begin
         s_in = -s_in;
      end
      if (neg_c) begin
         c_in = -c_in;
      end
   end

   // Hip bias 5 * error, moved from Q3.12 to the joint grid
   always_comb begin
      err18   = 18'(err);
      err5    = (err18 <<< 2) + err18;
      err_ext = VW'(err5);
      bias_in = W'(((err_ext + BRND) >>> BDN) <<< BUP);
   end

   // Velocity 0.45 + error / 10; the result always stays inside 16 bits
   always_comb begin
      vprod  = 31'(vel_num) * VEL_RECIP;
      vquo   = vprod[30:VEL_RECIP_SHIFT];
      vel_in = signed'(16'(vquo) + VEL_BASE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (adv) begin
         tok_ff <= tok_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff    <= s_in;
         c_ff    <= c_in;
         bias_ff <= bias_in;
         vel_ff  <= vel_in;
      end
   end

   assign tok_o = tok_ff;
   assign sin_s = s_ff;
   assign sin_c = c_ff;
   assign bias  = bias_ff;
   assign vel   = vel_ff;

endmodule

`default_nettype wire

/* design/sgjg_joint.sv */
// Joint angle arithmetic: products, sums, clamps and Q3.12 output register.
`default_nettype none
`include "sinusoidal_gait_joint_generator_macros.svh"

module sgjg_joint
   import sgjg_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire tok_type                         tok_i,
   input  wire logic signed [ANGLE_FRAC_BITS+2:0] sin_s,
   input  wire logic signed [ANGLE_FRAC_BITS+2:0] sin_c,
   input  wire logic signed [ANGLE_FRAC_BITS+7:0] bias,
   input  wire logic signed [15:0]              vel,
   output tok_type                              tok_o,
   output logic signed [14:0]                   pitch_top,
   output logic signed [14:0]                   roll_top,
   output logic signed [14:0]                   middle,
   output logic signed [14:0]                   end_angle,
   output logic signed [15:0]                   velocity
);

   localparam int F   = ANGLE_FRAC_BITS;
   localparam int W   = F + 8;
   localparam int QUP = (F < 12) ? 12 - F : 0;
   localparam int QDN = (F > 12) ? F - 12 : 0;
   localparam longint ONE = longint'(1) << F;
   localparam logic signed [2*W-1:0] MRND = (2*W)'(ONE >> 1);
   localparam logic signed [W-1:0]   QRND = W'((longint'(1) << QDN) >> 1);

   // Constants rounded to the joint grid
   localparam logic signed [W-1:0] K_0P15 = W'((15 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P42 = W'((42 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P18 = W'((18 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P85 = W'((85 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P65 = W'((65 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P06 = W'((6 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P35 = W'((35 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P55 = W'((55 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_0P25 = W'((25 * ONE + 50) / 100);
   localparam logic signed [W-1:0] K_1P8  = W'((18 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_0P8  = W'((8 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_0P3  = W'((3 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_2P6  = W'((26 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_0P6  = W'((6 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_0P5  = W'((5 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_2P0  = W'((20 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_1P5  = W'((15 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_0P2  = W'((2 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_3P0  = W'((30 * ONE + 5) / 10);
   localparam logic signed [W-1:0] K_1P0  = W'((10 * ONE + 5) / 10);

   // Product rounded half up back to the grid
   function automatic logic signed [W-1:0] mulr(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      logic signed [2*W-1:0] p;
      p = a * b;
      p = p + MRND;
      return W'(p >>> F);
   endfunction

   function automatic logic signed [W-1:0] clampw(input logic signed [W-1:0] v,
                                                  input logic signed [W-1:0] lo,
                                                  input logic signed [W-1:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Round half up (or widen) to Q3.12
   function automatic logic signed [14:0] to_q12(input logic signed [W-1:0] v);
      logic signed [W-1:0] t;
      t = (v + QRND) >>> QDN;
      t = t <<< QUP;
      return t[14:0];
   endfunction

   tok_type tok3_ff, tok4_ff, tok5_ff, tok6_ff;

   logic signed [W-1:0] s_w, sw_w, c_w;
   logic signed [W-1:0] pt3_ff, pt3_in, pm3_ff, pm3_in, pr3_ff, pr3_in, bias3_ff;
   logic signed [15:0]  vel3_ff, vel4_ff, vel5_ff, vel6_ff;
   logic signed [W-1:0] top4_ff, top4_in, mid4_ff, mid4_in;
   logic signed [W-1:0] diff4_ff, diff4_in, roll4_ff, roll4_in;
   logic signed [W-1:0] top5_ff, top5_in, mid5_ff, mid5_in;
   logic signed [W-1:0] roll5_ff, roll5_in, end5_ff, end5_in;
   logic signed [14:0]  top6_ff, top6_in, mid6_ff, mid6_in;
   logic signed [14:0]  roll6_ff, roll6_in, end6_ff, end6_in;
   logic leg3, leg4, leg5;

   assign leg3 = limb_is_leg(tok_i.limb);
   assign leg4 = limb_is_leg(tok3_ff.limb);
   assign leg5 = limb_is_leg(tok4_ff.limb);

   // Stage 3: sine products
   always_comb begin
      s_w    = W'(sin_s);
      c_w    = W'(sin_c);
      sw_w   = (s_w > 0) ? s_w : '0;
      pt3_in = mulr(leg3 ? K_0P42 : K_0P55, s_w);
      pm3_in = mulr(leg3 ? K_0P85 : K_0P65, sw_w);
      pr3_in = mulr(K_0P06, c_w);
   end

   // Stage 4: hip/shoulder, knee/elbow and their difference
   always_comb begin
      if (leg4) begin
         top4_in  = K_0P15 + pt3_ff + bias3_ff;
         mid4_in  = K_0P18 + pm3_ff;
         diff4_in = (K_0P18 - K_0P15) + pm3_ff - pt3_ff - bias3_ff;
         roll4_in = pr3_ff;
      end else begin
         top4_in  = pt3_ff - K_0P35;
         mid4_in  = K_0P25 + pm3_ff;
         diff4_in = (K_0P25 + K_0P35) + pm3_ff - pt3_ff;
         roll4_in = '0;
      end
   end

   // Stage 5: ankle/wrist product and the first clamps
   always_comb begin
      end5_in = mulr(diff4_ff, leg5 ? K_0P65 : K_0P5);
      if (leg5) begin
         top5_in  = clampw(top4_ff, -K_1P8, K_1P8);
         mid5_in  = clampw(mid4_ff, -K_0P3, K_2P6);
         roll5_in = clampw(roll4_ff, -K_0P8, K_0P8);
      end else begin
         top5_in  = clampw(top4_ff, -K_2P0, K_1P5);
         mid5_in  = clampw(mid4_ff, -K_0P2, K_3P0);
         roll5_in = roll4_ff;
      end
   end

   // Stage 6: last clamp and conversion into the output register
   always_comb begin
      top6_in  = to_q12(top5_ff);
      mid6_in  = to_q12(mid5_ff);
      roll6_in = to_q12(roll5_ff);
      if (limb_is_leg(tok5_ff.limb)) begin
         end6_in = to_q12(clampw(end5_ff, -K_0P6, K_0P8));
      end else begin
         end6_in = to_q12(clampw(end5_ff, -K_0P5, K_1P0));
      end
   end

   // Advance the valid tokens
   always_ff @(posedge clock) begin
      if (reset) begin
         tok3_ff <= '0;
         tok4_ff <= '0;
         tok5_ff <= '0;
         tok6_ff <= '0;
      end else if (adv) begin
         tok3_ff <= tok_i;
         tok4_ff <= tok3_ff;
         tok5_ff <= tok4_ff;
         tok6_ff <= tok5_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      if (adv) begin
         pt3_ff   <= pt3_in;
         pm3_ff   <= pm3_in;
         pr3_ff   <= pr3_in;
         bias3_ff <= bias;
         vel3_ff  <= vel;
         top4_ff  <= top4_in;
         mid4_ff  <= mid4_in;
         diff4_ff <= diff4_in;
         roll4_ff <= roll4_in;
         vel4_ff  <= vel3_ff;
         top5_ff  <= top5_in;
         mid5_ff  <= mid5_in;
         roll5_ff <= roll5_in;
         end5_ff  <= end5_in;
         vel5_ff  <= vel4_ff;
         top6_ff  <= top6_in;
         mid6_ff  <= mid6_in;
         roll6_ff <= roll6_in;
         end6_ff  <= end6_in;
         vel6_ff  <= vel5_ff;
      end
   end

   assign tok_o     = tok6_ff;
   assign pitch_top = top6_ff;
   assign roll_top  = roll6_ff;
   assign middle    = mid6_ff;
   assign end_angle = end6_ff;
   assign velocity  = vel6_ff;

   `SGJG_ASSERT_SAME(a_arm_roll_zero, clock, reset, tok6_ff.valid && !limb_is_leg(tok6_ff.limb), roll6_ff == '0, "arm beat carries a nonzero roll angle")
   `SGJG_ASSERT_SAME(a_pitch_range, clock, reset, tok6_ff.valid, (top6_ff <= 15'sd12288) && (top6_ff >= -15'sd12288), "pitch angle escaped its clamp")

endmodule

`default_nettype wire

/* design/sinusoidal_gait_joint_generator.sv */
// Top level of the sinusoidal gait joint generator.
// Each accepted request beat (time stamp, measured centre-of-mass height) yields four
// response beats in the order left leg, right leg, left arm, right arm, with tlast on the
// right arm. One response beat leaves per cycle while the response side does not stall, and
// a new request can be taken as the limb sequencer issues the last limb of the held one. The
// sequencer issues one limb per cycle, unless stalled, from the input hold register into a
// six-stage pipeline (phase decode, sine table lookup, products, sums, ankle/wrist product
// and clamps, output register). A stall on the response side freezes the whole pipeline;
// nothing is dropped or repeated.
`default_nettype none

module sinusoidal_gait_joint_generator
   import sgjg_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int ANGLE_FRAC_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // sim_time[31:0], com_height[45:32], zero pad
   input  wire logic        req_tuser,   // com_known
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // angle_pitch_top[14:0], angle_roll_top[29:15],
                                         // angle_middle[44:30], angle_end[59:45],
                                         // forward_velocity[75:60], zero pad
   output logic [1:0]       rsp_tuser,   // limb
   output logic             rsp_tlast
);

   localparam int F = ANGLE_FRAC_BITS;
   localparam int B = SINE_TABLE_BITS;

   logic adv;

   tok_type             tok1, tok2, tok_out;
   logic [B-2:0]        u_s, u_c;
   logic                neg_s, neg_c;
   logic signed [14:0]  err;
   logic [14:0]         vel_num;
   logic signed [F+2:0] sin_s, sin_c;
   logic signed [F+7:0] bias;
   logic signed [15:0]  vel;
   logic signed [14:0]  pitch_top, roll_top, middle, end_angle;
   logic signed [15:0]  velocity;

   // Move the whole pipeline unless a finished beat is waiting
   assign adv = !tok_out.valid || rsp_tready;

   sgjg_feed #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_feed (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sim_time   (req_tdata[31:0]),
      .com_height (req_tdata[45:32]),
      .com_known  (req_tuser),
      .tok        (tok1),
      .u_s        (u_s),
      .neg_s      (neg_s),
      .u_c        (u_c),
      .neg_c      (neg_c),
      .err        (err),
      .vel_num    (vel_num)
   );

   sgjg_sine #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS),
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_sine (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .tok_i   (tok1),
      .u_s     (u_s),
      .neg_s   (neg_s),
      .u_c     (u_c),
      .neg_c   (neg_c),
      .err     (err),
      .vel_num (vel_num),
      .tok_o   (tok2),
      .sin_s   (sin_s),
      .sin_c   (sin_c),
      .bias    (bias),
      .vel     (vel)
   );

   sgjg_joint #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_joint (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .tok_i     (tok2),
      .sin_s     (sin_s),
      .sin_c     (sin_c),
      .bias      (bias),
      .vel       (vel),
      .tok_o     (tok_out),
      .pitch_top (pitch_top),
      .roll_top  (roll_top),
      .middle    (middle),
      .end_angle (end_angle),
      .velocity  (velocity)
   );

   // Pack the response beat
   assign rsp_tvalid = tok_out.valid;
   assign rsp_tuser  = tok_out.limb;
   assign rsp_tlast  = (tok_out.limb == LIMB_RA);
   assign rsp_tdata  = {4'b0000, velocity, end_angle, middle, roll_top, pitch_top};

endmodule

`default_nettype wire

/* verif/sinusoidal_gait_joint_generator_test.sv */
// Self-checking testbench for the sinusoidal gait joint generator: directed table, then random.
module sinusoidal_gait_joint_generator_test
   import sgjg_pkg::*;
;
   localparam int SINE_BITS     = 10;
   localparam int FRAC_BITS     = 12;
   localparam int PHASE_BITS    = 18;
   localparam int NUM_DIRECTED  = 20;
   localparam int NUM_RANDOM    = 410;
   localparam int CALM_FIRST    = 100;
   localparam int CALM_LAST     = 200;
   localparam int HOLD_AT_ITEM  = 250;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_AT_ITEM = 330;
   localparam int TAIL_CYCLES   = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam logic [63:0] Q30_UNIT = 64'd1 << 30;
   localparam logic [63:0] HALF_PI  = 64'd1686629713;

   // One limb beat as it leaves the block
   typedef struct packed {
      limb_type    limb;
      logic [14:0] pitch;
      logic [14:0] roll;
      logic [14:0] middle;
      logic [14:0] distal;
      logic [15:0] velocity;
      logic        last;
   } gait_beat_type;

   // One directed request; typed rows take the phase-zero, zero-error limbs below
   typedef struct packed {
      logic [31:0] t;
      logic [13:0] h;
      logic        known;
      logic        typed;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [47:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_typed  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   gait_beat_type expected_limbs[$];
   int            error_count = 0;
   int            items_in    = 0;
   int            cycle_count = 0;
   int            stall_left  = 0;
   logic          stall_done  = 1'b0;

   // Phase zero with zero height error: hip and shoulder at rest, roll at its peaks
   gait_beat_type phase_zero_limbs [0:3] = '{
      '{LIMB_LL, 15'd614, 15'd246, 15'd737, 15'd80, 16'd1843, 1'b0},
      '{LIMB_RL, 15'd614, -15'sd246, 15'd737, 15'd80, 16'd1843, 1'b0},
      '{LIMB_LA, -15'sd1434, 15'd0, 15'd1024, 15'd1229, 16'd1843, 1'b0},
      '{LIMB_RA, -15'sd1434, 15'd0, 15'd1024, 15'd1229, 16'd1843, 1'b1}
   };

   stim_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{32'h0000_0000, 14'd0,     1'b0, 1'b1},
      '{32'h0000_0000, 14'd16383, 1'b0, 1'b1},
      '{32'h0000_0000, 14'd3768,  1'b1, 1'b1},
      '{32'h0000_0000, 14'd0,     1'b1, 1'b0},
      '{32'h0000_0000, 14'd16383, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 14'd0,     1'b1, 1'b0},
      '{32'hFFFF_FFFF, 14'd16383, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 14'd16383, 1'b0, 1'b0},
      '{32'h0001_0000, 14'd3768,  1'b1, 1'b0},
      '{32'h0002_0000, 14'd3768,  1'b1, 1'b0},
      '{32'h0003_0000, 14'd3768,  1'b1, 1'b0},
      '{32'h0004_0000, 14'd3768,  1'b1, 1'b0},
      '{32'd52428,     14'd3768,  1'b1, 1'b0},
      '{32'd13108,     14'd4000,  1'b1, 1'b0},
      '{32'd26215,     14'd3500,  1'b1, 1'b0},
      '{32'd39322,     14'd3768,  1'b0, 1'b0},
      '{32'hAAAA_AAAA, 14'h2AAA,  1'b1, 1'b0},
      '{32'h5555_5555, 14'h1555,  1'b0, 1'b0},
      '{32'h8000_0000, 14'h2000,  1'b1, 1'b0},
      '{32'h0000_0001, 14'd1,     1'b1, 1'b0}
   };

   sinusoidal_gait_joint_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Constant n/d on the joint grid, rounded to nearest
   function automatic longint fx_const(input longint n, input longint d);
      return (n * (longint'(1) << FRAC_BITS) + d / 2) / d;
   endfunction

   // Product back on the grid, ties toward plus infinity
   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic longint fx_clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Quarter-wave sine: Taylor series to x^11 in Q30, rounded to the joint grid
   function automatic longint gait_sine(input logic [SINE_BITS-1:0] idx);
      logic [1:0]           quad;
      logic [SINE_BITS-2:0] u;
      logic [63:0]          q;
      logic [63:0]          a;
      logic [63:0]          a2;
      logic [63:0]          r;
      logic [63:0]          s;
      longint               v;
      int                   n;
      quad = idx[SINE_BITS-1 -: 2];
      u    = {1'b0, idx[SINE_BITS-3:0]};
      // mirror odd quarters
      if (quad[0])
         u = (SINE_BITS-1)'((1 << (SINE_BITS - 2)) - u);
      q  = 64'(u) << (32 - SINE_BITS);
      a  = (q * HALF_PI) >> 30;
      a2 = (a * a) >> 30;
      r  = Q30_UNIT;
      for (n = 10; n >= 2; n = n - 2)
         r = Q30_UNIT - ((a2 * r) >> 30) / 64'(n * (n + 1));
      s = (a * r) >> 30;
      v = longint'((s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      return quad[1] ? -v : v;
   endfunction

   // Work out the four limb beats of one request and queue them
   function automatic void compute_gait_limbs(input logic [31:0] t, input logic [13:0] h,
                                              input logic known);
      logic [63:0]          frac;
      logic [SINE_BITS-1:0] base;
      logic [SINE_BITS-1:0] idx;
      longint               err;
      longint               bias;
      longint               num;
      longint               quot;
      longint               vel;
      longint               s;
      longint               sw;
      longint               drive;
      longint               bend;
      longint               tip;
      longint               sway;
      gait_beat_type        beat;
      int                   k;
      frac = (64'(t) * 64'd5) & ((64'd1 << PHASE_BITS) - 1);
      base = frac[PHASE_BITS-1 -: SINE_BITS];
      err  = known ? (longint'(3768) - longint'(h)) : longint'(0);
      bias = err * 5;
      // velocity 0.45 + err/10, floor of (err + 5) / 10
      num  = err + 5;
      quot = (num >= 0) ? num / 10 : -((-num + 9) / 10);
      vel  = fx_clamp(1843 + quot, -32768, 32767);
      for (k = 0; k < 4; k++) begin
         idx = SINE_BITS'(base + (((k == 1) || (k == 2)) ? (1 << (SINE_BITS - 1)) : 0));
         s   = gait_sine(idx);
         sw  = (s > 0) ? s : 0;
         beat.limb = limb_type'(2'(k));
         // ankle and wrist follow the unclamped upper joints
         if (k < 2) begin
            drive = fx_const(15, 100) + fx_mul(fx_const(42, 100), s) + bias;
            bend  = fx_const(18, 100) + fx_mul(fx_const(85, 100), sw);
            tip   = fx_mul(bend - drive, fx_const(65, 100));
            sway  = fx_mul(fx_const(6, 100),
                           gait_sine(SINE_BITS'(idx + (1 << (SINE_BITS - 2)))));
            beat.pitch  = 15'(fx_clamp(drive, -fx_const(18, 10), fx_const(18, 10)));
            beat.roll   = 15'(fx_clamp(sway, -fx_const(8, 10), fx_const(8, 10)));
            beat.middle = 15'(fx_clamp(bend, -fx_const(3, 10), fx_const(26, 10)));
            beat.distal = 15'(fx_clamp(tip, -fx_const(6, 10), fx_const(8, 10)));
         end else begin
            drive = -fx_const(35, 100) + fx_mul(fx_const(55, 100), s);
            bend  = fx_const(25, 100) + fx_mul(fx_const(65, 100), sw);
            tip   = fx_mul(bend - drive, fx_const(5, 10));
            beat.pitch  = 15'(fx_clamp(drive, -fx_const(20, 10), fx_const(15, 10)));
            beat.roll   = '0;
            beat.middle = 15'(fx_clamp(bend, -fx_const(2, 10), fx_const(30, 10)));
            beat.distal = 15'(fx_clamp(tip, -fx_const(5, 10), fx_const(10, 10)));
         end
         beat.velocity = 16'(vel);
         beat.last     = (k == 3);
         expected_limbs.push_back(beat);
      end
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Present one request beat and hold it until accepted
   task automatic send_request(input logic [31:0] t, input logic [13:0] h, input logic known,
                               input logic typed, input int seq);
      if (!(seq >= CALM_FIRST && seq < CALM_LAST) && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, h, t};
      req_tuser  <= known;
      req_typed  <= typed;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // Drop valid and wait until every queued limb beat has come out
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (expected_limbs.size() != 0);
      @(posedge clock);
   endtask

   // Check result beats, then predict for accepted request beats
   always @(posedge clock) begin : scoreboard
      gait_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_limbs.size() == 0) begin
               $display("%0t: unexpected limb beat, actual limb %0d tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = expected_limbs.pop_front();
               check_field("limb", 16'(want.limb), 16'(rsp_tuser));
               check_field("angle_pitch_top", 16'(want.pitch), 16'(rsp_tdata[14:0]));
               check_field("angle_roll_top", 16'(want.roll), 16'(rsp_tdata[29:15]));
               check_field("angle_middle", 16'(want.middle), 16'(rsp_tdata[44:30]));
               check_field("angle_end", 16'(want.distal), 16'(rsp_tdata[59:45]));
               check_field("forward_velocity", want.velocity, rsp_tdata[75:60]);
               check_field("last", 16'(want.last), 16'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_typed)
               foreach (phase_zero_limbs[j])
                  expected_limbs.push_back(phase_zero_limbs[j]);
            else
               compute_gait_limbs(req_tdata[31:0], req_tdata[45:32], req_tuser);
            items_in <= items_in + 1;
         end
      end
   end

   // Receiver: random stalls, a calm stretch, and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && items_in >= HOLD_AT_ITEM) begin
         rsp_tready <= 1'b0;
         stall_left <= HOLD_CYCLES - 1;
         stall_done <= 1'b1;
      end else if (items_in >= CALM_FIRST && items_in < CALM_LAST) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 14);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Stimulus: directed table, then random requests
   initial begin : stimulus
      int          i;
      int          pick;
      logic [31:0] t;
      logic [31:0] walk_time;
      logic [13:0] h;
      logic        known;
      walk_time = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < NUM_DIRECTED; i++)
         send_request(directed_rows[i].t, directed_rows[i].h, directed_rows[i].known,
                      directed_rows[i].typed, i);
      for (i = 0; i < NUM_RANDOM; i++) begin
         // mix of arbitrary stamps, early stamps and a steadily advancing clock
         pick = $urandom_range(99);
         if (pick < 40) begin
            t = $urandom;
         end else if (pick < 60) begin
            t = $urandom_range(32'h7FFFF, 0);
         end else begin
            walk_time = walk_time + $urandom_range(3000, 1);
            t = walk_time;
         end
         h     = ($urandom_range(99) < 60) ? 14'($urandom_range(4500, 3000)) : 14'($urandom);
         known = ($urandom_range(99) < 80);
         if (i == DRAIN_AT_ITEM)
            wait_for_drain();
         send_request(t, h, known, 1'b0, NUM_DIRECTED + i);
      end
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_limbs.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
